// ===== rtl/clt_pkg.sv =====
// shared types, character constants and codes of the command line tokenizer
package clt_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_EQUALS = 8'd61;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef enum logic [3:0] {
        CLS_EOC,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_DOT,
        CLS_QUOTE,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_EQUALS,
        CLS_STAR,
        CLS_SPACE,
        CLS_SEMI,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING,
        MODE_PAREN,
        MODE_CLOSED,
        MODE_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_WORD,
        KIND_NUMBER,
        KIND_STRING,
        KIND_PAREN,
        KIND_EQUALS,
        KIND_STAR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_OPEN_STRING,
        ERR_PAREN,
        ERR_SYMBOL
    } t_err;

    // one classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0] chr;
        t_cls       cls;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   empty;
        t_entry entry;
    } t_head;

endpackage

// ===== rtl/clt_if.sv =====
// handshake interfaces for the byte input and the token result channels
interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface clt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       take_char;
    logic [2:0] token_kind;
    logic       token_begins;
    logic       token_closed_before;
    logic [1:0] error_code;
    logic       command_done;

    modport source (
        output valid, output char_out, output take_char, output token_kind,
        output token_begins, output token_closed_before, output error_code,
        output command_done, input ready
    );
    modport sink (
        input valid, input char_out, input take_char, input token_kind,
        input token_begins, input token_closed_before, input error_code,
        input command_done, output ready
    );
endinterface

// ===== rtl/command_line_tokenizer.sv =====
// command line tokenizer: one byte in, one result beat out per cycle while the result side is not stalled
// an accepted beat is first written into the byte queue, then its result is registered in the back end
// throughput: one beat per cycle unless the result side stalls, set by the lexer step in the back end
// the byte queue lets input keep flowing while the result register is stalled, until the queue is full
// reset (synchronous, active low) empties the queue and returns the lexer to idle
module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clt_in_if.sink    i_in,
    clt_out_if.source o_out
);

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    clt_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    clt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    clt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/clt_front.sv =====
// front end: accepts input beats, upper-cases and classifies each byte
module clt_front
    import clt_pkg::*;
(
    clt_in_if.sink i_in,
    input  logic   i_full,
    output t_push  o_push
);

    logic [7:0] w_upper;
    t_cls       w_cls;

    always_comb begin
        if (i_in.char_in >= CH_LOWER_A && i_in.char_in <= CH_LOWER_Z) begin
            w_upper = i_in.char_in - CASE_OFFSET;
        end else begin
            w_upper = i_in.char_in;
        end
    end

    always_comb begin
        if (i_in.end_of_input || i_in.char_in == CH_NUL) begin
            w_cls = CLS_EOC;
        end else if (w_upper >= CH_UPPER_A && w_upper <= CH_UPPER_Z) begin
            w_cls = CLS_LETTER;
        end else if (w_upper >= CH_ZERO && w_upper <= CH_NINE) begin
            w_cls = CLS_DIGIT;
        end else if (w_upper == CH_SPACE || w_upper == CH_CR || w_upper == CH_LF
                     || w_upper == CH_TAB) begin
            w_cls = CLS_SPACE;
        end else if (w_upper == CH_DOT) begin
            w_cls = CLS_DOT;
        end else if (w_upper == CH_QUOTE) begin
            w_cls = CLS_QUOTE;
        end else if (w_upper == CH_LPAREN) begin
            w_cls = CLS_LPAREN;
        end else if (w_upper == CH_RPAREN) begin
            w_cls = CLS_RPAREN;
        end else if (w_upper == CH_EQUALS) begin
            w_cls = CLS_EQUALS;
        end else if (w_upper == CH_STAR) begin
            w_cls = CLS_STAR;
        end else if (w_upper == CH_SEMI) begin
            w_cls = CLS_SEMI;
        end else begin
            w_cls = CLS_OTHER;
        end
    end

    assign i_in.ready = !i_full;

    always_comb begin
        o_push.valid     = i_in.valid && !i_full;
        o_push.entry.cls = w_cls;
        // end of command carries no byte
        o_push.entry.chr = (w_cls == CLS_EOC) ? CH_NUL : w_upper;
    end

endmodule

// ===== rtl/clt_queue.sv =====
// short queue of classified bytes between front and back end
module clt_queue
    import clt_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

// ===== rtl/clt_back.sv =====
// back end: lexer state machine and registered result beat
module clt_back
    import clt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_head   i_head,
    output logic    o_pop,
    clt_out_if.source o_out
);

    typedef struct packed {
        logic  take;
        logic  raise;
        t_mode mode;
        t_kind kind;
    } t_start;

    typedef struct packed {
        logic [7:0] chr;
        logic       take;
        t_kind      kind;
        logic       begins;
        logic       closed;
        t_err       err;
        logic       done;
    } t_res;

    t_mode r_mode;
    t_mode n_mode;
    t_kind r_kind;
    t_kind n_kind;
    t_err  r_err;
    t_err  n_err;
    logic  r_out_valid;
    logic  n_out_valid;
    t_res  r_res;
    t_res  n_res;
    t_cls  w_cls;
    t_start w_start;

    // what a byte does when no token is open
    function automatic t_start start_token(input t_cls cls);
        t_start s;
        s.take  = 1'b1;
        s.raise = 1'b0;
        s.mode  = MODE_IDLE;
        s.kind  = KIND_NONE;
        unique case (cls)
            CLS_LETTER: begin
                s.mode = MODE_WORD;
                s.kind = KIND_WORD;
            end
            CLS_DIGIT: begin
                s.mode = MODE_NUMBER;
                s.kind = KIND_NUMBER;
            end
            CLS_QUOTE: begin
                s.mode = MODE_STRING;
                s.kind = KIND_STRING;
            end
            CLS_LPAREN: begin
                s.mode = MODE_PAREN;
                s.kind = KIND_PAREN;
            end
            CLS_EQUALS: begin
                s.mode = MODE_CLOSED;
                s.kind = KIND_EQUALS;
            end
            CLS_STAR: begin
                s.mode = MODE_CLOSED;
                s.kind = KIND_STAR;
            end
            CLS_SPACE, CLS_SEMI: begin
                s.take = 1'b0;
            end
            default: begin
                s.take  = 1'b0;
                s.raise = 1'b1;
                s.mode  = MODE_ERROR;
            end
        endcase
        return s;
    endfunction

    assign w_cls   = i_head.entry.cls;
    assign w_start = start_token(w_cls);
    assign o_pop   = !i_head.empty && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_mode = r_mode;
        n_kind = r_kind;
        n_err  = r_err;
        if (w_cls == CLS_EOC) begin
            n_mode = MODE_IDLE;
            n_kind = KIND_NONE;
            n_err  = ERR_NONE;
        end else begin
            unique case (r_mode)
                MODE_ERROR: begin
                end
                MODE_WORD: begin
                    if (w_cls != CLS_LETTER && w_cls != CLS_DIGIT) begin
                        n_mode = w_start.mode;
                        n_kind = w_start.kind;
                        if (w_start.raise) begin
                            n_err = ERR_SYMBOL;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (w_cls != CLS_DIGIT && w_cls != CLS_DOT) begin
                        n_mode = w_start.mode;
                        n_kind = w_start.kind;
                        if (w_start.raise) begin
                            n_err = ERR_SYMBOL;
                        end
                    end
                end
                MODE_STRING: begin
                    if (w_cls == CLS_QUOTE) begin
                        n_mode = MODE_CLOSED;
                    end
                end
                MODE_PAREN: begin
                    if (w_cls == CLS_RPAREN) begin
                        n_mode = MODE_CLOSED;
                    end else if (w_cls != CLS_SPACE && w_cls != CLS_DIGIT) begin
                        n_mode = MODE_ERROR;
                        n_kind = KIND_NONE;
                        n_err  = ERR_PAREN;
                    end
                end
                default: begin
                    n_mode = w_start.mode;
                    n_kind = w_start.kind;
                    if (w_start.raise) begin
                        n_err = ERR_SYMBOL;
                    end
                end
            endcase
        end
    end

    // result of the byte at the queue head
    always_comb begin
        n_res.chr    = i_head.entry.chr;
        n_res.take   = 1'b0;
        n_res.begins = 1'b0;
        n_res.closed = 1'b0;
        n_res.done   = 1'b0;
        n_res.err    = n_err;
        if (w_cls == CLS_EOC) begin
            n_res.done   = 1'b1;
            n_res.closed = (r_mode == MODE_WORD) || (r_mode == MODE_NUMBER)
                           || (r_mode == MODE_CLOSED);
            n_res.err    = r_err;
            if (r_err == ERR_NONE) begin
                if (r_mode == MODE_STRING) begin
                    n_res.err = ERR_OPEN_STRING;
                end else if (r_mode == MODE_PAREN) begin
                    n_res.err = ERR_PAREN;
                end
            end
        end else begin
            unique case (r_mode)
                MODE_ERROR: begin
                end
                MODE_WORD: begin
                    if (w_cls == CLS_LETTER || w_cls == CLS_DIGIT) begin
                        n_res.take = 1'b1;
                    end else begin
                        n_res.closed = 1'b1;
                        n_res.take   = w_start.take;
                        n_res.begins = w_start.take;
                    end
                end
                MODE_NUMBER: begin
                    if (w_cls == CLS_DIGIT || w_cls == CLS_DOT) begin
                        n_res.take = 1'b1;
                    end else begin
                        n_res.closed = 1'b1;
                        n_res.take   = w_start.take;
                        n_res.begins = w_start.take;
                    end
                end
                MODE_STRING: begin
                    n_res.take = 1'b1;
                end
                MODE_PAREN: begin
                    n_res.take = (w_cls == CLS_DIGIT) || (w_cls == CLS_RPAREN);
                end
                MODE_CLOSED: begin
                    n_res.closed = 1'b1;
                    n_res.take   = w_start.take;
                    n_res.begins = w_start.take;
                end
                default: begin
                    n_res.take   = w_start.take;
                    n_res.begins = w_start.take;
                end
            endcase
        end
        n_res.kind = n_res.take ? n_kind : KIND_NONE;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_kind      <= KIND_NONE;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_mode <= n_mode;
                r_kind <= n_kind;
                r_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.char_out            = r_res.chr;
    assign o_out.take_char           = r_res.take;
    assign o_out.token_kind          = r_res.kind;
    assign o_out.token_begins        = r_res.begins;
    assign o_out.token_closed_before = r_res.closed;
    assign o_out.error_code          = r_res.err;
    assign o_out.command_done        = r_res.done;

endmodule

// ===== verif/tb_checker.sv =====
// tokenizer result checker: predicts each result beat and compares it with the block
`timescale 1ns / 100ps

module tb_checker
    import clt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    clt_in_if    in_ch,
    clt_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] chr;
        logic       take;
        t_kind      kind;
        logic       begins;
        logic       closed;
        t_err       err;
        logic       done;
    } lex_beat_t;

    // lexer state as the block should hold it
    t_mode lex_mode;
    t_kind tok_kind;
    t_err  held_err;

    lex_beat_t token_results_due[$];
    int        fails = 0;
    int        beats_seen = 0;

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic letter_byte(input logic [7:0] c);
        return c >= CH_UPPER_A && c <= CH_UPPER_Z;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
    endfunction

    function automatic void clear_lexer();
        lex_mode = MODE_IDLE;
        tok_kind = KIND_NONE;
        held_err = ERR_NONE;
    endfunction

    function automatic void raise_error(input t_err code);
        held_err = code;
        lex_mode = MODE_ERROR;
        tok_kind = KIND_NONE;
    endfunction

    // byte seen with no token open; returns 1 when it starts one
    function automatic logic open_token(input logic [7:0] u, output logic begins);
        begins = 1'b0;
        if (is_space(u) || u == CH_SEMI)
            return 1'b0;
        if (letter_byte(u)) begin
            lex_mode = MODE_WORD;
            tok_kind = KIND_WORD;
        end else if (digit_byte(u)) begin
            lex_mode = MODE_NUMBER;
            tok_kind = KIND_NUMBER;
        end else if (u == CH_QUOTE) begin
            lex_mode = MODE_STRING;
            tok_kind = KIND_STRING;
        end else if (u == CH_LPAREN) begin
            lex_mode = MODE_PAREN;
            tok_kind = KIND_PAREN;
        end else if (u == CH_EQUALS) begin
            lex_mode = MODE_CLOSED;
            tok_kind = KIND_EQUALS;
        end else if (u == CH_STAR) begin
            lex_mode = MODE_CLOSED;
            tok_kind = KIND_STAR;
        end else begin
            raise_error(ERR_SYMBOL);
            return 1'b0;
        end
        begins = 1'b1;
        return 1'b1;
    endfunction

    function automatic lex_beat_t lex_step(input logic [7:0] c, input logic eoi);
        lex_beat_t  b;
        logic [7:0] u;
        logic       take;
        logic       begins;
        logic       closed;
        b      = '0;
        take   = 1'b0;
        begins = 1'b0;
        closed = 1'b0;
        u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;

        if (eoi || c == CH_NUL) begin
            b.closed = lex_mode == MODE_WORD || lex_mode == MODE_NUMBER ||
                       lex_mode == MODE_CLOSED;
            b.err = held_err;
            if (held_err == ERR_NONE) begin
                if (lex_mode == MODE_STRING)
                    b.err = ERR_OPEN_STRING;
                else if (lex_mode == MODE_PAREN)
                    b.err = ERR_PAREN;
            end
            b.done = 1'b1;
            clear_lexer();
            return b;
        end

        case (lex_mode)
            MODE_ERROR: begin
            end
            MODE_WORD: begin
                if (letter_byte(u) || digit_byte(u)) begin
                    take = 1'b1;
                end else begin
                    closed   = 1'b1;
                    lex_mode = MODE_IDLE;
                    tok_kind = KIND_NONE;
                    take     = open_token(u, begins);
                end
            end
            MODE_NUMBER: begin
                if (digit_byte(u) || u == CH_DOT) begin
                    take = 1'b1;
                end else begin
                    closed   = 1'b1;
                    lex_mode = MODE_IDLE;
                    tok_kind = KIND_NONE;
                    take     = open_token(u, begins);
                end
            end
            MODE_STRING: begin
                take = 1'b1;
                if (u == CH_QUOTE)
                    lex_mode = MODE_CLOSED;
            end
            MODE_PAREN: begin
                // whitespace inside the group is dropped silently
                if (is_space(u)) begin
                    take = 1'b0;
                end else if (digit_byte(u)) begin
                    take = 1'b1;
                end else if (u == CH_RPAREN) begin
                    take     = 1'b1;
                    lex_mode = MODE_CLOSED;
                end else begin
                    raise_error(ERR_PAREN);
                end
            end
            MODE_CLOSED: begin
                closed   = 1'b1;
                lex_mode = MODE_IDLE;
                tok_kind = KIND_NONE;
                take     = open_token(u, begins);
            end
            default: begin
                lex_mode = MODE_IDLE;
                tok_kind = KIND_NONE;
                take     = open_token(u, begins);
            end
        endcase

        b.chr    = u;
        b.take   = take;
        b.kind   = take ? tok_kind : KIND_NONE;
        b.begins = begins;
        b.closed = closed;
        b.err    = held_err;
        b.done   = 1'b0;
        return b;
    endfunction

    always @(posedge i_clk) begin
        lex_beat_t want;
        lex_beat_t got;
        if (!i_rst_n) begin
            clear_lexer();
            token_results_due.delete();
        end else begin
            if (in_ch.valid && in_ch.ready)
                token_results_due.insert(token_results_due.size(),
                                         lex_step(in_ch.char_in, in_ch.end_of_input));
            if (out_ch.valid && out_ch.ready) begin
                got.chr    = out_ch.char_out;
                got.take   = out_ch.take_char;
                got.kind   = t_kind'(out_ch.token_kind);
                got.begins = out_ch.token_begins;
                got.closed = out_ch.token_closed_before;
                got.err    = t_err'(out_ch.error_code);
                got.done   = out_ch.command_done;
                if (token_results_due.size() == 0) begin
                    if (fails < 10)
                        $display("result beat %0d arrived with nothing outstanding",
                                 beats_seen);
                    fails++;
                end else begin
                    want = token_results_due.pop_front();
                    if (got !== want) begin
                        if (fails < 10)
                            $display("result beat %0d: expected chr=%h take=%b kind=%0d ",
                                     beats_seen, want.chr, want.take, want.kind,
                                     "begins=%b closed=%b err=%0d done=%b, got chr=%h ",
                                     want.begins, want.closed, want.err, want.done,
                                     got.chr,
                                     "take=%b kind=%0d begins=%b closed=%b err=%0d done=%b",
                                     got.take, got.kind, got.begins,
                                     got.closed, got.err, got.done);
                        fails++;
                    end
                end
                beats_seen++;
            end
        end
        o_pending    <= token_results_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top: drives command bytes and back-pressure into the tokenizer, gives the verdict
`timescale 1ns / 100ps

module tb_top
    import clt_pkg::*;
();

    localparam int STALL_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;

    clt_in_if  in_ch ();
    clt_out_if out_ch ();

    int fail_count;
    int pending_beats;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int beats_sent;
    int quiet_cycles = 0;

    command_line_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random back-pressure, or a long hold-off when one is asked for
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.char_in      <= c;
        in_ch.end_of_input <= eoi;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // command ends either on a nul byte or on the end flag with a junk byte
    task automatic send_end();
        if ($urandom_range(1))
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        else
            send_beat(CH_NUL, 1'b0);
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] l;
        l = CH_UPPER_A + 8'($urandom_range(0, 25));
        if ($urandom_range(1))
            l = l + CASE_OFFSET;
        return l;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            default: return CH_SEMI;
        endcase
    endfunction

    task automatic send_token(input t_kind which);
        logic [7:0] b;
        case (which)
            KIND_WORD: begin
                send_beat(pick_letter(), 1'b0);
                repeat ($urandom_range(0, 5))
                    send_beat($urandom_range(1) ? pick_letter() : pick_digit(), 1'b0);
            end
            KIND_NUMBER: begin
                send_beat(pick_digit(), 1'b0);
                repeat ($urandom_range(0, 5))
                    send_beat(($urandom_range(3) == 0) ? CH_DOT : pick_digit(), 1'b0);
            end
            KIND_STRING: begin
                send_beat(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_QUOTE)
                        b = CH_DOT;
                    send_beat(b, 1'b0);
                end
                send_beat(CH_QUOTE, 1'b0);
            end
            KIND_PAREN: begin
                send_beat(CH_LPAREN, 1'b0);
                repeat ($urandom_range(0, 4)) begin
                    // now and then a stray letter breaks the group
                    if ($urandom_range(99) < 6)
                        send_beat(pick_letter(), 1'b0);
                    else
                        send_beat($urandom_range(2) == 0 ? pick_separator() : pick_digit(),
                                  1'b0);
                end
                send_beat(CH_RPAREN, 1'b0);
            end
            KIND_EQUALS: send_beat(CH_EQUALS, 1'b0);
            default:     send_beat(CH_STAR, 1'b0);
        endcase
    endtask

    task automatic send_command();
        int n;
        int r;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8)
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            else
                send_token(t_kind'($urandom_range(1, 6)));
            r = $urandom_range(99);
            if (r < 60)
                send_beat(pick_separator(), 1'b0);
            else if (r < 75)
                repeat ($urandom_range(2, 4)) send_beat(pick_separator(), 1'b0);
        end
        // broken tails: a string or a group left open at end of command
        r = $urandom_range(99);
        if (r < 6) begin
            send_beat(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_beat(pick_letter(), 1'b0);
        end else if (r < 10) begin
            send_beat(CH_LPAREN, 1'b0);
            repeat ($urandom_range(0, 2)) send_beat(pick_digit(), 1'b0);
        end
        send_end();
    endtask

    task automatic run_phase(input int quota);
        int target;
        target = beats_sent + quota;
        while (beats_sent < target) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 8)) send_beat(8'($urandom_range(0, 255)), 1'b0);
                send_end();
            end else begin
                send_command();
            end
        end
    endtask

    // sender goes quiet until every outstanding result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0)
            @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.char_in      <= CH_NUL;
        in_ch.end_of_input <= 1'b0;
        i_rst_n            <= 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 56;
        hold_cycles   = 0;
        beats_sent    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // words, a separator, equals and star, then end flag right after a token
        send_text("a9;Zz=*");
        send_beat(8'hFF, 1'b1);
        // string left open, high byte taken inside it
        send_text("\"q");
        send_beat(8'hFF, 1'b0);
        send_beat(CH_NUL, 1'b0);
        // digit group with whitespace dropped, trailing whitespace
        send_text("(\t1)");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_NUL, 1'b1);
        // empty group, then a letter inside a group, error held
        send_text("()(x7");
        send_beat(CH_NUL, 1'b0);
        // number ended by an unsupported high byte
        send_text("0.");
        send_beat(8'h80, 1'b0);
        send_beat(CH_NUL, 1'b1);
        // group open at end of command
        send_text("(");
        send_beat(8'h5A, 1'b1);
        // empty command
        send_beat(CH_NUL, 1'b0);
        drain();

        run_phase(420);
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 8;
        run_phase(420);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        run_phase(410);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/clt_pkg.sv
rtl/clt_if.sv
rtl/clt_front.sv
rtl/clt_queue.sv
rtl/clt_back.sv
rtl/command_line_tokenizer.sv
verif/tb_checker.sv
verif/tb_top.sv
